>>> hdl/aat_pkg.sv
// Shared types and constants of the affine box transform.
// Used by the channel interfaces, the row datapath and the top level.
`default_nettype none

package aat_pkg;

   localparam int CENTER_W   = 32;
   localparam int EXTENT_W   = 31;
   localparam int ENTRY_W    = 16;
   localparam int COLUMN_W   = 48;
   localparam int TRANS_W    = 32;
   localparam int FRAC_SHIFT = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_X    = 3'd0,
      CSR_COLUMN_Y    = 3'd1,
      CSR_COLUMN_Z    = 3'd2,
      CSR_TRANSLATE_X = 3'd3,
      CSR_TRANSLATE_Y = 3'd4,
      CSR_TRANSLATE_Z = 3'd5
   } csr_index_type;

   localparam logic [COLUMN_W-1:0] COLUMN_X_RESET = 48'h0000_0000_1000;
   localparam logic [COLUMN_W-1:0] COLUMN_Y_RESET = 48'h0000_1000_0000;
   localparam logic [COLUMN_W-1:0] COLUMN_Z_RESET = 48'h1000_0000_0000;

   // Load enables for the two pipeline stages held inside a row.
   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } stage_adv_type;

endpackage

`default_nettype wire

>>> hdl/aat_if.sv
// Valid/ready channel interfaces of the affine box transform.
// Depends on aat_pkg for the field widths.
`default_nettype none

interface aat_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [aat_pkg::CENTER_W-1:0] center_x;
   logic signed [aat_pkg::CENTER_W-1:0] center_y;
   logic signed [aat_pkg::CENTER_W-1:0] center_z;
   logic        [aat_pkg::EXTENT_W-1:0] extent_x;
   logic        [aat_pkg::EXTENT_W-1:0] extent_y;
   logic        [aat_pkg::EXTENT_W-1:0] extent_z;

   modport source (output valid, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, input ready);
   modport sink   (input valid, center_x, center_y, center_z,
                   extent_x, extent_y, extent_z, output ready);
endinterface

interface aat_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [aat_pkg::CENTER_W-1:0] new_center_x;
   logic signed [aat_pkg::CENTER_W-1:0] new_center_y;
   logic signed [aat_pkg::CENTER_W-1:0] new_center_z;
   logic        [aat_pkg::EXTENT_W-1:0] new_extent_x;
   logic        [aat_pkg::EXTENT_W-1:0] new_extent_y;
   logic        [aat_pkg::EXTENT_W-1:0] new_extent_z;

   modport source (output valid, new_center_x, new_center_y, new_center_z,
                   new_extent_x, new_extent_y, new_extent_z, input ready);
   modport sink   (input valid, new_center_x, new_center_y, new_center_z,
                   new_extent_x, new_extent_y, new_extent_z, output ready);
endinterface

interface aat_csr_if;
   logic                              valid;
   logic                              ready;
   logic [aat_pkg::CSR_IDX_W-1:0]     index;
   logic [aat_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/aat_row.sv
// One output component of the transform: product stage and sum stage.
// Depends on aat_pkg; pipeline enables come from the top level.
`default_nettype none

module aat_row #(
   parameter int COORD_WIDTH = 32
) (
   input  wire                                       clock,
   input  wire aat_pkg::stage_adv_type               adv,
   input  wire logic signed [COORD_WIDTH-1:0]        corner_lo [3],
   input  wire logic signed [COORD_WIDTH-1:0]        corner_hi [3],
   input  wire logic signed [aat_pkg::ENTRY_W-1:0]   entry [3],
   input  wire logic signed [aat_pkg::TRANS_W-1:0]   translate,
   output logic signed [COORD_WIDTH-1:0]             new_lo,
   output logic signed [COORD_WIDTH-1:0]             new_hi
);

   localparam int FULL_W = COORD_WIDTH + aat_pkg::ENTRY_W;
   localparam int PROD_W = FULL_W - aat_pkg::FRAC_SHIFT;
   localparam int SUM_W  = ((PROD_W > aat_pkg::TRANS_W) ? PROD_W : aat_pkg::TRANS_W) + 2;

   localparam logic signed [SUM_W-1:0] SAT_MAX =
      {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

   logic signed [PROD_W-1:0] small_ff [3];
   logic signed [PROD_W-1:0] large_ff [3];
   logic signed [PROD_W-1:0] small_in [3];
   logic signed [PROD_W-1:0] large_in [3];
   logic signed [COORD_WIDTH-1:0] new_lo_ff, new_hi_ff;
   logic signed [COORD_WIDTH-1:0] new_lo_in, new_hi_in;
   logic signed [SUM_W-1:0] sum_lo, sum_hi;

   // The low corner never exceeds the high one, so the sign of the matrix
   // entry alone tells which of the two products is the smaller.
   always_comb begin
      logic signed [FULL_W-1:0] full_lo;
      logic signed [FULL_W-1:0] full_hi;
      for (int a = 0; a < 3; a++) begin
         full_lo = entry[a] * corner_lo[a];
         full_hi = entry[a] * corner_hi[a];
         if (entry[a][aat_pkg::ENTRY_W-1]) begin
            small_in[a] = full_hi[FULL_W-1:aat_pkg::FRAC_SHIFT];
            large_in[a] = full_lo[FULL_W-1:aat_pkg::FRAC_SHIFT];
         end else begin
            small_in[a] = full_lo[FULL_W-1:aat_pkg::FRAC_SHIFT];
            large_in[a] = full_hi[FULL_W-1:aat_pkg::FRAC_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.prod_en) begin
         small_ff <= small_in;
         large_ff <= large_in;
      end
   end

   always_comb begin
      sum_lo = {{(SUM_W-aat_pkg::TRANS_W){translate[aat_pkg::TRANS_W-1]}}, translate};
      sum_hi = sum_lo;
      for (int a = 0; a < 3; a++) begin
         sum_lo = sum_lo + {{(SUM_W-PROD_W){small_ff[a][PROD_W-1]}}, small_ff[a]};
         sum_hi = sum_hi + {{(SUM_W-PROD_W){large_ff[a][PROD_W-1]}}, large_ff[a]};
      end
      priority if (sum_lo > SAT_MAX) new_lo_in = SAT_MAX[COORD_WIDTH-1:0];
      else if (sum_lo < SAT_MIN)     new_lo_in = SAT_MIN[COORD_WIDTH-1:0];
      else                           new_lo_in = sum_lo[COORD_WIDTH-1:0];
      priority if (sum_hi > SAT_MAX) new_hi_in = SAT_MAX[COORD_WIDTH-1:0];
      else if (sum_hi < SAT_MIN)     new_hi_in = SAT_MIN[COORD_WIDTH-1:0];
      else                           new_hi_in = sum_hi[COORD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.sum_en) begin
         new_lo_ff <= new_lo_in;
         new_hi_ff <= new_hi_in;
      end
   end

   assign new_lo = new_lo_ff;
   assign new_hi = new_hi_ff;

endmodule

`default_nettype wire

>>> hdl/aabb_affine_transform_top.sv
// Affine transform of axis-aligned boxes given as center and half size.
// A result passes through the corner, product, sum and output registers in turn;
// throughput is one box per cycle while the output takes results.
// Each stage holds a beat and moves it on whenever the next stage is free, so
// a stalled output blocks input only once all four stages are full.
// Synchronous active-high reset empties the pipeline and restores the identity map.
`default_nettype none

module aabb_affine_transform_top #(
   parameter int COORD_WIDTH = 32
) (
   input wire clock,
   input wire reset,
   aat_req_if.sink   req_ch,
   aat_rsp_if.source rsp_ch,
   aat_csr_if.sink   csr_ch
);

   localparam int CORNER_W = ((COORD_WIDTH > aat_pkg::CENTER_W) ?
                              COORD_WIDTH : aat_pkg::CENTER_W) + 2;
   localparam int OUT_W    = ((COORD_WIDTH + 1 > aat_pkg::CENTER_W + 1) ?
                              COORD_WIDTH + 1 : aat_pkg::CENTER_W + 1);
   localparam logic signed [CORNER_W-1:0] SAT_MAX =
      {{(CORNER_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [CORNER_W-1:0] SAT_MIN = ~SAT_MAX;

   // Configuration registers.
   logic [aat_pkg::COLUMN_W-1:0]       column_ff [3];
   logic signed [aat_pkg::TRANS_W-1:0] translate_ff [3];

   // Pipeline control.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic adv1, adv2, adv3, adv4;
   aat_pkg::stage_adv_type row_adv;

   // Datapath registers.
   logic signed [COORD_WIDTH-1:0] lo_ff [3];
   logic signed [COORD_WIDTH-1:0] hi_ff [3];
   logic signed [COORD_WIDTH-1:0] lo_in [3];
   logic signed [COORD_WIDTH-1:0] hi_in [3];
   logic signed [COORD_WIDTH-1:0] new_lo [3];
   logic signed [COORD_WIDTH-1:0] new_hi [3];
   logic signed [aat_pkg::CENTER_W-1:0] center_ff [3];
   logic signed [aat_pkg::CENTER_W-1:0] center_in [3];
   logic [aat_pkg::EXTENT_W-1:0] extent_ff [3];
   logic [aat_pkg::EXTENT_W-1:0] extent_in [3];
   logic signed [aat_pkg::CENTER_W-1:0] req_center [3];
   logic [aat_pkg::EXTENT_W-1:0] req_extent [3];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff[0]    <= aat_pkg::COLUMN_X_RESET;
         column_ff[1]    <= aat_pkg::COLUMN_Y_RESET;
         column_ff[2]    <= aat_pkg::COLUMN_Z_RESET;
         translate_ff[0] <= '0;
         translate_ff[1] <= '0;
         translate_ff[2] <= '0;
      end else if (csr_ch.valid) begin
         unique case (aat_pkg::csr_index_type'(csr_ch.index))
            aat_pkg::CSR_COLUMN_X:    column_ff[0] <= csr_ch.data;
            aat_pkg::CSR_COLUMN_Y:    column_ff[1] <= csr_ch.data;
            aat_pkg::CSR_COLUMN_Z:    column_ff[2] <= csr_ch.data;
            aat_pkg::CSR_TRANSLATE_X: translate_ff[0] <= csr_ch.data[aat_pkg::TRANS_W-1:0];
            aat_pkg::CSR_TRANSLATE_Y: translate_ff[1] <= csr_ch.data[aat_pkg::TRANS_W-1:0];
            aat_pkg::CSR_TRANSLATE_Z: translate_ff[2] <= csr_ch.data[aat_pkg::TRANS_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its beat moves on this cycle.
   assign adv4 = !s4_valid_ff || rsp_ch.ready;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ch.ready   = adv1;
   assign row_adv.prod_en = adv2;
   assign row_adv.sum_en  = adv3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_ch.valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   assign req_center[0] = req_ch.center_x;
   assign req_center[1] = req_ch.center_y;
   assign req_center[2] = req_ch.center_z;
   assign req_extent[0] = req_ch.extent_x;
   assign req_extent[1] = req_ch.extent_y;
   assign req_extent[2] = req_ch.extent_z;

   // Box corners, saturated to the coordinate width.
   always_comb begin
      logic signed [CORNER_W-1:0] c_wide;
      logic signed [CORNER_W-1:0] e_wide;
      logic signed [CORNER_W-1:0] lo_wide;
      logic signed [CORNER_W-1:0] hi_wide;
      for (int a = 0; a < 3; a++) begin
         c_wide  = {{(CORNER_W-aat_pkg::CENTER_W){req_center[a][aat_pkg::CENTER_W-1]}},
                    req_center[a]};
         e_wide  = {{(CORNER_W-aat_pkg::EXTENT_W){1'b0}}, req_extent[a]};
         lo_wide = c_wide - e_wide;
         hi_wide = c_wide + e_wide;
         priority if (lo_wide > SAT_MAX) lo_in[a] = SAT_MAX[COORD_WIDTH-1:0];
         else if (lo_wide < SAT_MIN)     lo_in[a] = SAT_MIN[COORD_WIDTH-1:0];
         else                            lo_in[a] = lo_wide[COORD_WIDTH-1:0];
         priority if (hi_wide > SAT_MAX) hi_in[a] = SAT_MAX[COORD_WIDTH-1:0];
         else if (hi_wide < SAT_MIN)     hi_in[a] = SAT_MIN[COORD_WIDTH-1:0];
         else                            hi_in[a] = hi_wide[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [aat_pkg::ENTRY_W-1:0] row_entry [3];
      for (genvar a = 0; a < 3; a++) begin : g_entry
         assign row_entry[a] = column_ff[a][aat_pkg::ENTRY_W*r +: aat_pkg::ENTRY_W];
      end
      aat_row #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_row (
         .clock     (clock),
         .adv       (row_adv),
         .corner_lo (lo_ff),
         .corner_hi (hi_ff),
         .entry     (row_entry),
         .translate (translate_ff[r]),
         .new_lo    (new_lo[r]),
         .new_hi    (new_hi[r])
      );
   end

   // Center and half size; bits above the floor shift are the low output bits.
   always_comb begin
      logic signed [OUT_W-1:0] lo_x;
      logic signed [OUT_W-1:0] hi_x;
      logic signed [OUT_W-1:0] sum_x;
      logic signed [OUT_W-1:0] diff_x;
      for (int r = 0; r < 3; r++) begin
         lo_x   = {{(OUT_W-COORD_WIDTH){new_lo[r][COORD_WIDTH-1]}}, new_lo[r]};
         hi_x   = {{(OUT_W-COORD_WIDTH){new_hi[r][COORD_WIDTH-1]}}, new_hi[r]};
         sum_x  = lo_x + hi_x;
         diff_x = hi_x - lo_x;
         center_in[r] = sum_x[aat_pkg::CENTER_W:1];
         extent_in[r] = diff_x[aat_pkg::EXTENT_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         center_ff <= center_in;
         extent_ff <= extent_in;
      end
   end

   assign rsp_ch.valid        = s4_valid_ff;
   assign rsp_ch.new_center_x = center_ff[0];
   assign rsp_ch.new_center_y = center_ff[1];
   assign rsp_ch.new_center_z = center_ff[2];
   assign rsp_ch.new_extent_x = extent_ff[0];
   assign rsp_ch.new_extent_y = extent_ff[1];
   assign rsp_ch.new_extent_z = extent_ff[2];

   // An accepted beat always lands in the corner stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> s1_valid_ff)
      else $error("accepted beat did not enter the corner stage");

   // Input stalls only when every stage holds a beat and the output is blocked.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff
                         && !rsp_ch.ready))
      else $error("input stalled while the pipeline had room");

   // A blocked result keeps its value until taken.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         (rsp_ch.valid && $stable(center_ff[0]) && $stable(extent_ff[0])))
      else $error("stalled result changed");

   // The sum stage advances a beat from the product stage without loss.
   a_sum_stage: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && adv3) |=> s3_valid_ff)
      else $error("beat lost between product and sum stages");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the affine box transform, aabb_affine_transform_top.
// Depends on aat_pkg and the channel interfaces in aat_if.sv. It predicts every
// transformed box from its own copy of the matrix and translation registers.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH = 32;
   localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   // Register indexes that decode to nothing; writes to them must be dropped.
   localparam logic [aat_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [aat_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [aat_pkg::CENTER_W-1:0] CENTER_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [aat_pkg::CENTER_W-1:0] CENTER_MIN = 32'sh8000_0000;
   localparam logic [aat_pkg::EXTENT_W-1:0]        EXTENT_MAX = 31'h7FFF_FFFF;

   typedef struct {
      logic signed [aat_pkg::CENTER_W-1:0] center[3];
      logic        [aat_pkg::EXTENT_W-1:0] extent[3];
   } aabb_type;

   logic clock;
   logic reset;

   aat_req_if req_ch ();
   aat_rsp_if rsp_ch ();
   aat_csr_if csr_ch ();

   aabb_affine_transform_top #(.COORD_WIDTH(COORD_WIDTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   aabb_type       boxes_to_send[$];
   aabb_type       predicted_boxes[$];
   logic [aat_pkg::COLUMN_W-1:0] column_reg[3];
   logic [aat_pkg::TRANS_W-1:0]  translate_reg[3];
   int             send_idle_pct;
   int             recv_idle_pct;
   int             failures;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Interval arithmetic: each column is scaled by both corners of its axis, the
   // smaller product feeds the new lower corner and the larger the upper one.
   function automatic aabb_type transform_box(aabb_type b);
      aabb_type result;
      longint lo[3];
      longint hi[3];
      longint sum_lo, sum_hi, m, p, q, cen, ext;
      for (int a = 0; a < 3; a++) begin
         lo[a] = clamp_coord(longint'(b.center[a]) - longint'(b.extent[a]));
         hi[a] = clamp_coord(longint'(b.center[a]) + longint'(b.extent[a]));
      end
      for (int r = 0; r < 3; r++) begin
         sum_lo = longint'(signed'(translate_reg[r]));
         sum_hi = sum_lo;
         for (int a = 0; a < 3; a++) begin
            m = longint'(signed'(column_reg[a][aat_pkg::ENTRY_W*r +: aat_pkg::ENTRY_W]));
            p = (m * lo[a]) >>> aat_pkg::FRAC_SHIFT;
            q = (m * hi[a]) >>> aat_pkg::FRAC_SHIFT;
            if (p < q) begin
               sum_lo += p;
               sum_hi += q;
            end else begin
               sum_lo += q;
               sum_hi += p;
            end
         end
         sum_lo = clamp_coord(sum_lo);
         sum_hi = clamp_coord(sum_hi);
         cen = (sum_lo + sum_hi) >>> 1;
         ext = (sum_hi - sum_lo) >>> 1;
         result.center[r] = cen[aat_pkg::CENTER_W-1:0];
         result.extent[r] = ext[aat_pkg::EXTENT_W-1:0];
      end
      return result;
   endfunction

   // Sender: a new beat is offered whenever the channel is free, unless it idles.
   always @(posedge clock) begin : drive_boxes
      aabb_type next_box;
      aabb_type taken_box;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken_box.center[0] = req_ch.center_x;
            taken_box.center[1] = req_ch.center_y;
            taken_box.center[2] = req_ch.center_z;
            taken_box.extent[0] = req_ch.extent_x;
            taken_box.extent[1] = req_ch.extent_y;
            taken_box.extent[2] = req_ch.extent_z;
            predicted_boxes.push_back(transform_box(taken_box));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (boxes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_box = boxes_to_send.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.center_x <= next_box.center[0];
               req_ch.center_y <= next_box.center[1];
               req_ch.center_z <= next_box.center[2];
               req_ch.extent_x <= next_box.extent[0];
               req_ch.extent_y <= next_box.extent[1];
               req_ch.extent_z <= next_box.extent[2];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : check_boxes
      aabb_type want;
      aabb_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.center[0] = rsp_ch.new_center_x;
         got.center[1] = rsp_ch.new_center_y;
         got.center[2] = rsp_ch.new_center_z;
         got.extent[0] = rsp_ch.new_extent_x;
         got.extent[1] = rsp_ch.new_extent_y;
         got.extent[2] = rsp_ch.new_extent_z;
         if (predicted_boxes.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, center %0d %0d %0d", $time,
                     got.center[0], got.center[1], got.center[2]);
         end else begin
            want = predicted_boxes.pop_front();
            for (int r = 0; r < 3; r++) begin
               if (got.center[r] !== want.center[r]) begin
                  failures++;
                  $display("%0t: new_center[%0d] expected %0d actual %0d", $time, r,
                           want.center[r], got.center[r]);
               end
               if (got.extent[r] !== want.extent[r]) begin
                  failures++;
                  $display("%0t: new_extent[%0d] expected %0d actual %0d", $time, r,
                           want.extent[r], got.extent[r]);
               end
            end
         end
      end
   end

   // Called at a rising edge; leaves valid high so back-to-back writes stay legal.
   task automatic write_register(logic [aat_pkg::CSR_IDX_W-1:0] index,
                                 logic [aat_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         aat_pkg::CSR_COLUMN_X:    column_reg[0] = value[aat_pkg::COLUMN_W-1:0];
         aat_pkg::CSR_COLUMN_Y:    column_reg[1] = value[aat_pkg::COLUMN_W-1:0];
         aat_pkg::CSR_COLUMN_Z:    column_reg[2] = value[aat_pkg::COLUMN_W-1:0];
         aat_pkg::CSR_TRANSLATE_X: translate_reg[0] = value[aat_pkg::TRANS_W-1:0];
         aat_pkg::CSR_TRANSLATE_Y: translate_reg[1] = value[aat_pkg::TRANS_W-1:0];
         aat_pkg::CSR_TRANSLATE_Z: translate_reg[2] = value[aat_pkg::TRANS_W-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits of the translation writes are junk the block must drop.
   task automatic write_transform(logic [aat_pkg::COLUMN_W-1:0] cx,
                                  logic [aat_pkg::COLUMN_W-1:0] cy,
                                  logic [aat_pkg::COLUMN_W-1:0] cz,
                                  logic [aat_pkg::TRANS_W-1:0] tx,
                                  logic [aat_pkg::TRANS_W-1:0] ty,
                                  logic [aat_pkg::TRANS_W-1:0] tz);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_register(aat_pkg::CSR_COLUMN_X, cx);
      write_register(aat_pkg::CSR_COLUMN_Y, cy);
      write_register(aat_pkg::CSR_COLUMN_Z, cz);
      write_register(aat_pkg::CSR_TRANSLATE_X, {junk, tx});
      write_register(aat_pkg::CSR_TRANSLATE_Y, {~junk, ty});
      write_register(aat_pkg::CSR_TRANSLATE_Z, {junk ^ 16'h5A5A, tz});
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [aat_pkg::COLUMN_W-1:0] random_column();
      if ($urandom_range(1))
         return aat_pkg::COLUMN_W'({$urandom, $urandom});
      // Entries within about two units, the range of rotations and mild scales.
      return {16'($urandom_range(16383)) - 16'd8192, 16'($urandom_range(16383)) - 16'd8192,
              16'($urandom_range(16383)) - 16'd8192};
   endfunction

   task automatic write_random_transform();
      write_transform(random_column(), random_column(), random_column(),
                      $urandom, $urandom, $urandom);
   endtask

   task automatic add_box(logic signed [aat_pkg::CENTER_W-1:0] cx,
                          logic signed [aat_pkg::CENTER_W-1:0] cy,
                          logic signed [aat_pkg::CENTER_W-1:0] cz,
                          logic [aat_pkg::EXTENT_W-1:0] ex,
                          logic [aat_pkg::EXTENT_W-1:0] ey,
                          logic [aat_pkg::EXTENT_W-1:0] ez);
      aabb_type b;
      b.center[0] = cx;
      b.center[1] = cy;
      b.center[2] = cz;
      b.extent[0] = ex;
      b.extent[1] = ey;
      b.extent[2] = ez;
      boxes_to_send.push_back(b);
   endtask

   task automatic add_directed_boxes();
      add_box(0, 0, 0, 0, 0, 0);
      add_box(CENTER_MAX, CENTER_MAX, CENTER_MAX, 0, 0, 0);
      add_box(CENTER_MIN, CENTER_MIN, CENTER_MIN, 0, 0, 0);
      add_box(0, 0, 0, EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
      // Corners that run past the coordinate range on one side.
      add_box(CENTER_MAX, CENTER_MAX, CENTER_MAX, EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
      add_box(CENTER_MIN, CENTER_MIN, CENTER_MIN, EXTENT_MAX, EXTENT_MAX, EXTENT_MAX);
      add_box(CENTER_MAX, CENTER_MIN, 0, EXTENT_MAX, 0, 1);
      // Odd and negative sums exercise the floor halving.
      add_box(-1, -1, -1, 1, 2, 3);
      add_box(1, -3, 5, 3, 0, 1);
      add_box(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 31'h8000, 31'h1_0000, 31'h1);
      add_box(-32'sh7FFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA,
              EXTENT_MAX, 31'h2AAA_AAAA, 31'h5555_5555);
      add_box(32'sh0000_0FFF, -32'sh0000_1001, 32'sh7FFF_0000, 31'hFFF, 31'h1001, 31'h1_0000);
   endtask

   function automatic logic signed [aat_pkg::CENTER_W-1:0] random_center();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(2097151)) - 32'd1048576;
         2: case ($urandom_range(4))
               0: return CENTER_MAX;
               1: return CENTER_MIN;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         default: return $signed($urandom) >>> 8;
      endcase
   endfunction

   function automatic logic [aat_pkg::EXTENT_W-1:0] random_extent();
      case ($urandom_range(3))
         0: return 31'($urandom);
         1: return 31'($urandom_range(1048576));
         2: case ($urandom_range(2))
               0: return 0;
               1: return 1;
               default: return EXTENT_MAX;
            endcase
         default: return 31'($urandom >> 8);
      endcase
   endfunction

   task automatic add_random_boxes(int count);
      repeat (count)
         add_box(random_center(), random_center(), random_center(),
                 random_extent(), random_extent(), random_extent());
   endtask

   // Returns at a rising edge once every beat is out and the pipeline has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (boxes_to_send.size() != 0 || req_ch.valid || predicted_boxes.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      failures      = 0;
      send_idle_pct = 20;
      recv_idle_pct = 53;
      req_ch.valid  = 1'b0;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.center_z = '0;
      req_ch.extent_x = '0;
      req_ch.extent_y = '0;
      req_ch.extent_z = '0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = '0;
      csr_ch.data   = '0;
      column_reg[0] = aat_pkg::COLUMN_X_RESET;
      column_reg[1] = aat_pkg::COLUMN_Y_RESET;
      column_reg[2] = aat_pkg::COLUMN_Z_RESET;
      translate_reg[0] = '0;
      translate_reg[1] = '0;
      translate_reg[2] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Identity map straight out of reset.
      add_directed_boxes();
      add_random_boxes(250);
      wait_drained();

      write_register(CSR_SPARE_LO, aat_pkg::COLUMN_W'({$urandom, $urandom}));
      write_register(CSR_SPARE_HI, aat_pkg::COLUMN_W'({$urandom, $urandom}));
      write_random_transform();
      add_random_boxes(250);
      wait_drained();

      // Most negative entries with the largest translation: sums pin at both limits.
      send_idle_pct = 53;
      recv_idle_pct = 20;
      write_transform(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_directed_boxes();
      add_random_boxes(200);
      wait_drained();

      write_transform(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_random_boxes(200);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_random_transform();
      add_random_boxes(250);
      wait_drained();

      // A zero matrix collapses every box onto the translation point.
      write_transform('0, '0, '0, $urandom, $urandom, $urandom);
      add_random_boxes(100);
      wait_drained();

      write_random_transform();
      add_random_boxes(150);
      wait_drained();

      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
